/* hw/rtl/btc_pkg.sv */
// ============================================================================
// btc_pkg: shared types and constants for barometric trim compensation
// Holds the unpacked trim record, the register indexes and port widths.
// ============================================================================
`default_nettype none

package btc_pkg;

    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 48;

    // Register indexes of the configuration port.
    localparam logic [CFG_IDX_W-1:0] IDX_TRIM_TEMP    = 3'd0;
    localparam logic [CFG_IDX_W-1:0] IDX_TRIM_PRESS_A = 3'd1;
    localparam logic [CFG_IDX_W-1:0] IDX_TRIM_PRESS_B = 3'd2;
    localparam logic [CFG_IDX_W-1:0] IDX_TRIM_PRESS_C = 3'd3;
    localparam logic [CFG_IDX_W-1:0] IDX_TRIM_VALID   = 3'd4;

    // Bias removed from the two sensitivity trim words.
    localparam logic signed [16:0] SENS_BIAS = 17'sd16384;

    // Unpacked trim words.
    typedef struct packed {
        logic        [15:0] t1;
        logic        [15:0] t2;
        logic signed [7:0]  t3;
        logic signed [15:0] p1;
        logic signed [15:0] p2;
        logic signed [7:0]  p3;
        logic signed [7:0]  p4;
        logic        [15:0] p5;
        logic        [15:0] p6;
        logic signed [7:0]  p7;
        logic signed [7:0]  p8;
        logic signed [15:0] p9;
        logic signed [7:0]  p10;
        logic signed [7:0]  p11;
        logic               valid;
    } trim_t;

endpackage

`default_nettype wire

/* hw/rtl/btc_mul.sv */
// ============================================================================
// btc_mul: registered signed multiplier
// One signed product per cycle, registered at the output.
// ============================================================================
`default_nettype none

module btc_mul #(
    parameter int AW = 16,
    parameter int BW = 16
) (
    input  wire logic                     clk,
    input  wire logic signed [AW-1:0]     a,
    input  wire logic signed [BW-1:0]     b,
    output logic signed      [AW+BW-1:0]  p
);

    logic signed [AW+BW-1:0] p_reg;

    always_ff @(posedge clk)
    begin
        p_reg <= a * b;
    end

    assign p = p_reg;

endmodule

`default_nettype wire

/* hw/rtl/btc_trim_regs.sv */
// ============================================================================
// btc_trim_regs: trim word register file
// Holds the written trim words and presents them unpacked.
// ============================================================================
`default_nettype none

module btc_trim_regs (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           cfg_we,
    input  wire logic [btc_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [btc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output btc_pkg::trim_t                      trim
);
    import btc_pkg::*;

    logic [39:0] temp_reg;
    logic [47:0] press_a_reg;
    logic [47:0] press_b_reg;
    logic [31:0] press_c_reg;
    logic        valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            temp_reg    <= '0;
            press_a_reg <= '0;
            press_b_reg <= '0;
            press_c_reg <= '0;
            valid_reg   <= 1'b0;
        end
        else if (cfg_we)
        begin
            case (cfg_idx)
                IDX_TRIM_TEMP:    temp_reg    <= cfg_wdata[39:0];
                IDX_TRIM_PRESS_A: press_a_reg <= cfg_wdata[47:0];
                IDX_TRIM_PRESS_B: press_b_reg <= cfg_wdata[47:0];
                IDX_TRIM_PRESS_C: press_c_reg <= cfg_wdata[31:0];
                IDX_TRIM_VALID:   valid_reg   <= cfg_wdata[0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        trim.t1    = temp_reg[15:0];
        trim.t2    = temp_reg[31:16];
        trim.t3    = $signed(temp_reg[39:32]);
        trim.p1    = $signed(press_a_reg[15:0]);
        trim.p2    = $signed(press_a_reg[31:16]);
        trim.p3    = $signed(press_a_reg[39:32]);
        trim.p4    = $signed(press_a_reg[47:40]);
        trim.p5    = press_b_reg[15:0];
        trim.p6    = press_b_reg[31:16];
        trim.p7    = $signed(press_b_reg[39:32]);
        trim.p8    = $signed(press_b_reg[47:40]);
        trim.p9    = $signed(press_c_reg[15:0]);
        trim.p10   = $signed(press_c_reg[23:16]);
        trim.p11   = $signed(press_c_reg[31:24]);
        trim.valid = valid_reg;
    end

endmodule

`default_nettype wire

/* hw/rtl/barometric_trim_compensation.sv */
// ============================================================================
// barometric_trim_compensation: pipelined pressure and temperature correction
// Linearizes temperature and corrects pressure from factory trim words.
// ============================================================================
//
// Usage. Load the four trim words and then set trim_valid through the write
// port (cfg_we, cfg_idx, cfg_wdata); writes take effect at once. The user must see
// that writes are made only while no item is in flight; the block does not
// enforce it. An item (raw_press, raw_temp) is taken at every rising edge with
// start high; busy is always low, so a new item may enter in every cycle. Each
// result item appears on press_q6, temp_q16 and error_code for exactly one
// cycle with done high, once its item has passed from stage 0 through to the
// output register of stage 12. The sustained rate is one item per cycle; between
// an item and its result lie the thirteen register stages of the multiplier chain,
// where temperature squared and cubed and the pressure products each need a
// multiply stage and an accumulate stage. The receiver cannot stall, so the
// pipeline never holds. Reset empties the pipeline (no done strobe until new
// items arrive) and clears all trim words, so items report error_code 1 with
// zero outputs until trim_valid is written.
//
`default_nettype none

module barometric_trim_compensation (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire logic                           start,
    output logic                                busy,
    input  wire logic [23:0]                    raw_press,
    input  wire logic [23:0]                    raw_temp,
    output logic                                done,
    output logic [23:0]                         press_q6,
    output logic signed [23:0]                  temp_q16,
    output logic                                error_code,
    input  wire logic                           cfg_we,
    input  wire logic [btc_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  wire logic [btc_pkg::CFG_DATA_W-1:0] cfg_wdata
);
    import btc_pkg::*;

    trim_t trim;

    btc_trim_regs u_regs (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_idx   (cfg_idx),
        .cfg_wdata (cfg_wdata),
        .trim      (trim)
    );

    assign busy = 1'b0;

    // Valid bits for stages 0 through 11; stage 12 is the output register.
    logic [11:0] vld_reg;
    logic        done_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg  <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            vld_reg  <= {vld_reg[10:0], start & ~busy};
            done_reg <= vld_reg[11];
        end
    end

    // Trim words in signed operand form.
    logic signed [16:0] t2_s, p5_s, p6_s, p1m_s, p2m_s;
    logic signed [24:0] pr_s;

    assign t2_s  = $signed({1'b0, trim.t2});
    assign p5_s  = $signed({1'b0, trim.p5});
    assign p6_s  = $signed({1'b0, trim.p6});
    assign p1m_s = 17'(trim.p1) - SENS_BIAS;
    assign p2m_s = 17'(trim.p2) - SENS_BIAS;

    // ---------------------------------------------------------------- stage 0
    // Offset raw temperature, capture the pressure count and trim status.
    logic [23:0]        p_line_reg   [0:9];
    logic               err_line_reg [0:11];
    logic signed [33:0] a0_reg;

    always_ff @(posedge clk)
    begin
        p_line_reg[0]   <= raw_press;
        err_line_reg[0] <= ~trim.valid;
        a0_reg          <= $signed({2'b00, raw_temp, 8'h00}) - $signed({18'h0, trim.t1});
        for (int k = 1; k < 10; k++)
        begin
            p_line_reg[k] <= p_line_reg[k-1];
        end
        for (int k = 1; k < 12; k++)
        begin
            err_line_reg[k] <= err_line_reg[k-1];
        end
    end

    assign pr_s = $signed({1'b0, p_line_reg[0]});

    // ---------------------------------------------------------------- stage 1
    logic signed [50:0] at2_m;
    logic signed [41:0] at3_m;
    logic signed [49:0] pp_m;
    logic signed [32:0] pk_m;
    logic signed [33:0] a1_reg;

    btc_mul #(.AW(34), .BW(17)) u_mul_at2 (.clk(clk), .a(a0_reg), .b(t2_s),      .p(at2_m));
    btc_mul #(.AW(34), .BW(8))  u_mul_at3 (.clk(clk), .a(a0_reg), .b(trim.t3),   .p(at3_m));
    btc_mul #(.AW(25), .BW(25)) u_mul_pp  (.clk(clk), .a(pr_s),   .b(pr_s),      .p(pp_m));
    btc_mul #(.AW(25), .BW(8))  u_mul_pk  (.clk(clk), .a(pr_s),   .b(trim.p11),  .p(pk_m));

    always_ff @(posedge clk)
    begin
        a1_reg <= a0_reg;
    end

    // ---------------------------------------------------------------- stage 2
    // The wide products are split on the low bits of one operand.
    logic signed [21:0] at3_lo;
    logic signed [20:0] at3_hi;
    logic signed [55:0] a2t3l_m;
    logic signed [54:0] a2t3h_m;
    logic signed [25:0] pp_lo;
    logic signed [24:0] pp_hi;
    logic signed [58:0] pql_m;
    logic signed [57:0] pqh_m;
    logic signed [50:0] at2_2_reg;
    logic signed [49:0] pp_line_reg [2:5];
    logic signed [82:0] pq_line_reg [3:10];

    assign at3_lo = $signed({1'b0, at3_m[20:0]});
    assign at3_hi = $signed(at3_m[41:21]);
    assign pp_lo  = $signed({1'b0, pp_m[24:0]});
    assign pp_hi  = $signed(pp_m[49:25]);

    btc_mul #(.AW(22), .BW(34)) u_mul_a2t3l (.clk(clk), .a(at3_lo), .b(a1_reg), .p(a2t3l_m));
    btc_mul #(.AW(21), .BW(34)) u_mul_a2t3h (.clk(clk), .a(at3_hi), .b(a1_reg), .p(a2t3h_m));
    btc_mul #(.AW(26), .BW(33)) u_mul_pql   (.clk(clk), .a(pp_lo),  .b(pk_m),   .p(pql_m));
    btc_mul #(.AW(25), .BW(33)) u_mul_pqh   (.clk(clk), .a(pp_hi),  .b(pk_m),   .p(pqh_m));

    always_ff @(posedge clk)
    begin
        at2_2_reg      <= at2_m;
        pp_line_reg[2] <= pp_m;
        for (int k = 3; k < 6; k++)
        begin
            pp_line_reg[k] <= pp_line_reg[k-1];
        end
        pq_line_reg[3] <= (83'(pqh_m) <<< 25) + 83'(pql_m);
        for (int k = 4; k < 11; k++)
        begin
            pq_line_reg[k] <= pq_line_reg[k-1];
        end
    end

    // ---------------------------------------------------------------- stage 3
    // Linearized temperature in Q32.
    logic signed [77:0] tacc;
    logic signed [44:0] tq_line_reg [3:11];

    assign tacc = (78'(at2_2_reg) <<< 26) + (78'(a2t3h_m) <<< 21) + 78'(a2t3l_m);

    always_ff @(posedge clk)
    begin
        tq_line_reg[3] <= tacc[76:32];
        for (int k = 4; k < 12; k++)
        begin
            tq_line_reg[k] <= tq_line_reg[k-1];
        end
    end

    // ---------------------------------------------------------------- stage 4
    // Square of the temperature is split on the low 23 bits of one operand.
    logic signed [23:0] tq3_lo;
    logic signed [21:0] tq3_hi;
    logic signed [68:0] sql_m;
    logic signed [66:0] sqh_m;
    logic signed [61:0] m6_m, m2_m;
    logic signed [52:0] m10_m;

    assign tq3_lo = $signed({1'b0, tq_line_reg[3][22:0]});
    assign tq3_hi = $signed(tq_line_reg[3][44:23]);

    btc_mul #(.AW(45), .BW(24)) u_mul_sql (.clk(clk), .a(tq_line_reg[3]), .b(tq3_lo),
                                           .p(sql_m));
    btc_mul #(.AW(45), .BW(22)) u_mul_sqh (.clk(clk), .a(tq_line_reg[3]), .b(tq3_hi),
                                           .p(sqh_m));
    btc_mul #(.AW(17), .BW(45)) u_mul_m6  (.clk(clk), .a(p6_s), .b(tq_line_reg[3]),
                                           .p(m6_m));
    btc_mul #(.AW(17), .BW(45)) u_mul_m2  (.clk(clk), .a(p2m_s), .b(tq_line_reg[3]),
                                           .p(m2_m));
    btc_mul #(.AW(8), .BW(45))  u_mul_m10 (.clk(clk), .a(trim.p10), .b(tq_line_reg[3]),
                                           .p(m10_m));

    // ---------------------------------------------------------------- stage 5
    logic signed [87:0] sqacc;
    logic signed [54:0] t2q5_reg;
    logic signed [52:0] r80_5_reg;
    logic signed [61:0] m6_5_reg, m2_5_reg;

    assign sqacc = (88'(sqh_m) <<< 23) + 88'(sql_m);

    always_ff @(posedge clk)
    begin
        t2q5_reg  <= sqacc[86:32];
        r80_5_reg <= (53'(trim.p9) <<< 32) + m10_m;
        m6_5_reg  <= m6_m;
        m2_5_reg  <= m2_m;
    end

    // ---------------------------------------------------------------- stage 6
    logic signed [23:0] tq5_lo;
    logic signed [21:0] tq5_hi;
    logic signed [26:0] r80_lo, r80_hi;
    logic signed [78:0] cl_m;
    logic signed [76:0] ch_m, prl_m, prh_m;
    logic signed [62:0] m7_m, m3_m;
    logic signed [61:0] m6_6_reg, m2_6_reg;

    assign tq5_lo = $signed({1'b0, tq_line_reg[5][22:0]});
    assign tq5_hi = $signed(tq_line_reg[5][44:23]);
    assign r80_lo = $signed({1'b0, r80_5_reg[25:0]});
    assign r80_hi = $signed(r80_5_reg[52:26]);

    btc_mul #(.AW(55), .BW(24)) u_mul_cl  (.clk(clk), .a(t2q5_reg), .b(tq5_lo), .p(cl_m));
    btc_mul #(.AW(55), .BW(22)) u_mul_ch  (.clk(clk), .a(t2q5_reg), .b(tq5_hi), .p(ch_m));
    btc_mul #(.AW(8), .BW(55))  u_mul_m7  (.clk(clk), .a(trim.p7), .b(t2q5_reg), .p(m7_m));
    btc_mul #(.AW(8), .BW(55))  u_mul_m3  (.clk(clk), .a(trim.p3), .b(t2q5_reg), .p(m3_m));
    btc_mul #(.AW(50), .BW(27)) u_mul_prl (.clk(clk), .a(pp_line_reg[5]), .b(r80_lo),
                                           .p(prl_m));
    btc_mul #(.AW(50), .BW(27)) u_mul_prh (.clk(clk), .a(pp_line_reg[5]), .b(r80_hi),
                                           .p(prh_m));

    always_ff @(posedge clk)
    begin
        m6_6_reg <= m6_5_reg;
        m2_6_reg <= m2_5_reg;
    end

    // ---------------------------------------------------------------- stage 7
    // Cube of the temperature, the quadratic pressure term and partial sums.
    logic signed [98:0]  cacc;
    logic signed [100:0] pracc;
    logic signed [57:0]  t3q7_reg;
    logic signed [84:0]  prs7_reg;
    logic signed [95:0]  off7_reg;
    logic signed [69:0]  s7_reg;

    assign cacc  = (99'(ch_m) <<< 23) + 99'(cl_m);
    assign pracc = (101'(prh_m) <<< 26) + 101'(prl_m);

    always_ff @(posedge clk)
    begin
        t3q7_reg <= cacc[97:40];
        prs7_reg <= pracc[100:16];
        off7_reg <= (96'(p5_s) <<< 67) + (96'(m6_6_reg) <<< 26) + (96'(m7_m) <<< 24);
        s7_reg   <= (70'(p1m_s) <<< 44) + (70'(m2_6_reg) <<< 3) + 70'(m3_m);
    end

    // ---------------------------------------------------------------- stage 8
    logic signed [65:0] m8_m, m4_m;
    logic signed [95:0] off8_reg;
    logic signed [69:0] s8_reg;
    logic signed [84:0] prs8_reg;

    btc_mul #(.AW(8), .BW(58)) u_mul_m8 (.clk(clk), .a(trim.p8), .b(t3q7_reg), .p(m8_m));
    btc_mul #(.AW(8), .BW(58)) u_mul_m4 (.clk(clk), .a(trim.p4), .b(t3q7_reg), .p(m4_m));

    always_ff @(posedge clk)
    begin
        off8_reg <= off7_reg;
        s8_reg   <= s7_reg;
        prs8_reg <= prs7_reg;
    end

    // ---------------------------------------------------------------- stage 9
    logic signed [69:0] sacc;
    logic signed [95:0] off9_reg;
    logic signed [53:0] s48_9_reg;
    logic signed [84:0] prs9_reg;

    assign sacc = s8_reg + (70'(m4_m) <<< 3);

    always_ff @(posedge clk)
    begin
        off9_reg  <= off8_reg + (96'(m8_m) <<< 25);
        s48_9_reg <= sacc[69:16];
        prs9_reg  <= prs8_reg;
    end

    // --------------------------------------------------------------- stage 10
    logic signed [24:0] p9_s;
    logic signed [27:0] s48_lo;
    logic signed [26:0] s48_hi;
    logic signed [52:0] psl_m;
    logic signed [51:0] psh_m;
    logic signed [95:0] off10_reg;
    logic signed [84:0] prs10_reg;

    assign p9_s   = $signed({1'b0, p_line_reg[9]});
    assign s48_lo = $signed({1'b0, s48_9_reg[26:0]});
    assign s48_hi = $signed(s48_9_reg[53:27]);

    btc_mul #(.AW(25), .BW(28)) u_mul_psl (.clk(clk), .a(p9_s), .b(s48_lo), .p(psl_m));
    btc_mul #(.AW(25), .BW(27)) u_mul_psh (.clk(clk), .a(p9_s), .b(s48_hi), .p(psh_m));

    always_ff @(posedge clk)
    begin
        off10_reg <= off9_reg;
        prs10_reg <= prs9_reg;
    end

    // --------------------------------------------------------------- stage 11
    // Full pressure sum in Q64 Pa, with the rounding half added.
    logic signed [95:0] ps_full;
    logic signed [95:0] acc11_reg;

    assign ps_full = ((96'(psh_m) <<< 27) + 96'(psl_m)) <<< 16;

    always_ff @(posedge clk)
    begin
        acc11_reg <= off10_reg + ps_full + 96'(prs10_reg)
                     + (96'(pq_line_reg[10]) >>> 1) + (96'sd1 <<< 57);
    end

    // --------------------------------------------------------------- stage 12
    // Scale, saturate and select the error response.
    logic signed [37:0] pres_s;
    logic signed [45:0] tsum;
    logic signed [29:0] tres_s;
    logic [23:0]        press_next;
    logic signed [23:0] temp_next;
    logic [23:0]        press_q6_reg;
    logic signed [23:0] temp_q16_reg;
    logic               error_code_reg;

    assign pres_s = $signed(acc11_reg[95:58]);
    assign tsum   = 46'(tq_line_reg[11]) + 46'sd32768;
    assign tres_s = $signed(tsum[45:16]);

    always_comb
    begin
        if (pres_s < 38'sd0)
        begin
            press_next = 24'h000000;
        end
        else if (pres_s > 38'sd16777215)
        begin
            press_next = 24'hFFFFFF;
        end
        else
        begin
            press_next = pres_s[23:0];
        end

        if (tres_s < -30'sd8388608)
        begin
            temp_next = -24'sd8388608;
        end
        else if (tres_s > 30'sd8388607)
        begin
            temp_next = 24'sd8388607;
        end
        else
        begin
            temp_next = tres_s[23:0];
        end

        if (err_line_reg[11])
        begin
            press_next = 24'h000000;
            temp_next  = 24'sd0;
        end
    end

    always_ff @(posedge clk)
    begin
        press_q6_reg   <= press_next;
        temp_q16_reg   <= temp_next;
        error_code_reg <= err_line_reg[11];
    end

    assign done       = done_reg;
    assign press_q6   = press_q6_reg;
    assign temp_q16   = temp_q16_reg;
    assign error_code = error_code_reg;

endmodule

`default_nettype wire

/* hw/rtl/btc_checker.sv */
// ============================================================================
// btc_port_assertions: port level checks for barometric trim compensation
// Checks latency, strobe origin and the error response at the ports.
// ============================================================================
`default_nettype none

module btc_port_assertions (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           start,
    input wire logic                           busy,
    input wire logic [23:0]                    raw_press,
    input wire logic [23:0]                    raw_temp,
    input wire logic                           done,
    input wire logic [23:0]                    press_q6,
    input wire logic signed [23:0]             temp_q16,
    input wire logic                           error_code,
    input wire logic                           cfg_we,
    input wire logic [btc_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input wire logic [btc_pkg::CFG_DATA_W-1:0] cfg_wdata
);

    // Every accepted item yields its result with done high.
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |-> ##13 done)
        else $error("result missing 13 cycles after an accepted item");

    // No result appears without a matching accepted item.
    a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> $past(start && !busy, 13))
        else $error("result without a matching item");

    // An error result carries zero outputs.
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && error_code) |-> (press_q6 == 24'h0 && temp_q16 == 24'sd0))
        else $error("error result with nonzero outputs");

endmodule

bind barometric_trim_compensation btc_port_assertions u_btc_port_assertions (.*);

`default_nettype wire

/* verif/btc_checker.sv */
// ----------------------------------------------------------------------------
// btc_checker: result predictor and comparator for barometric trim compensation
// Tracks the trim registers from the write port, predicts each item's result
// in exact integer arithmetic, and compares every done strobe in order.
// ----------------------------------------------------------------------------
module btc_checker (
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           start,
    input  logic                           busy,
    input  logic [23:0]                    raw_press,
    input  logic [23:0]                    raw_temp,
    input  logic                           done,
    input  logic [23:0]                    press_q6,
    input  logic signed [23:0]             temp_q16,
    input  logic                           error_code,
    input  logic                           cfg_we,
    input  logic [btc_pkg::CFG_IDX_W-1:0]  cfg_idx,
    input  logic [btc_pkg::CFG_DATA_W-1:0] cfg_wdata,
    output int                             fail_count,
    output int                             pending_count,
    output int                             result_count
);
    timeunit 1ns;
    timeprecision 1ps;
    import btc_pkg::*;

    typedef struct packed {
        logic [23:0]        press;
        logic signed [23:0] temp;
        logic               err;
    } comp_result_t;

    logic [39:0] reg_temp;
    logic [47:0] reg_press_a;
    logic [47:0] reg_press_b;
    logic [31:0] reg_press_c;
    logic        reg_valid;

    comp_result_t expected_q[$];

    // Saturate a wide value into the signed 64-bit range.
    function automatic logic signed [63:0] clip64(input logic signed [255:0] v);
        if (v > 256'sh7FFFFFFFFFFFFFFF)
            return 64'sh7FFFFFFFFFFFFFFF;
        if (v < -256'sh8000000000000000)
            return 64'sh8000000000000000;
        return v[63:0];
    endfunction

    function automatic logic signed [127:0] wrap128(input logic signed [255:0] v);
        return v[127:0];
    endfunction

    function automatic comp_result_t compensate(input logic [23:0] rp, input logic [23:0] rt);
        comp_result_t r;
        logic signed [255:0] t1, t2, t3, p1, p2, p3, p4, p5, p6, p7, p8, p9, p10, p11;
        logic signed [255:0] pr, a, tq, t2q, t3q, s48, pp, r80, tout;
        logic signed [127:0] acc, s;
        r = '0;
        if (!reg_valid)
        begin
            r.err = 1'b1;
            return r;
        end
        t1  = $signed({1'b0, reg_temp[15:0]});
        t2  = $signed({1'b0, reg_temp[31:16]});
        t3  = $signed(reg_temp[39:32]);
        p1  = $signed(reg_press_a[15:0]);
        p2  = $signed(reg_press_a[31:16]);
        p3  = $signed(reg_press_a[39:32]);
        p4  = $signed(reg_press_a[47:40]);
        p5  = $signed({1'b0, reg_press_b[15:0]});
        p6  = $signed({1'b0, reg_press_b[31:16]});
        p7  = $signed(reg_press_b[39:32]);
        p8  = $signed(reg_press_b[47:40]);
        p9  = $signed(reg_press_c[15:0]);
        p10 = $signed(reg_press_c[23:16]);
        p11 = $signed(reg_press_c[31:24]);
        pr  = $signed({1'b0, rp});
        a   = $signed({1'b0, rt}) * 256 - t1;
        // Temperature in Q32, then its square and cube.
        acc = wrap128((a * t2) <<< 26) + wrap128(a * t3 * a);
        tq  = clip64(acc >>> 32);
        t2q = clip64(wrap128(tq * tq) >>> 32);
        t3q = clip64(wrap128(t2q * tq) >>> 40);
        // Offset terms, Q64 Pa.
        acc = wrap128(p5 <<< 67);
        acc = acc + wrap128(wrap128(p6 * tq) <<< 26);
        acc = acc + wrap128(wrap128(p7 * t2q) <<< 24);
        acc = acc + wrap128(wrap128(p8 * t3q) <<< 25);
        // Sensitivity, reduced to 48 fractional bits before the pressure product.
        s = wrap128((p1 - 16384) <<< 44);
        s = s + wrap128(wrap128((p2 - 16384) * tq) <<< 3);
        s = s + wrap128(p3 * t2q);
        s = s + wrap128(wrap128(p4 * t3q) <<< 3);
        s48 = clip64(s >>> 16);
        acc = acc + wrap128(wrap128(pr * s48) <<< 16);
        // Quadratic and cubic pressure terms.
        pp  = pr * pr;
        r80 = clip64(p9 * 256'sd4294967296 + p10 * tq);
        acc = acc + (wrap128(pp * r80) >>> 16);
        acc = acc + (wrap128(pp * (pr * p11)) >>> 1);
        acc = acc + (128'sd1 <<< 57);
        a = clip64(acc >>> 58);
        if (a < 0)
            a = 0;
        if (a > 256'sd16777215)
            a = 256'sd16777215;
        r.press = a[23:0];
        tout = (tq + 32768) >>> 16;
        if (tout < -256'sd8388608)
            tout = -256'sd8388608;
        if (tout > 256'sd8388607)
            tout = 256'sd8388607;
        r.temp = tout[23:0];
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        comp_result_t exp_r;
        if (!rst_n)
        begin
            reg_temp      <= '0;
            reg_press_a   <= '0;
            reg_press_b   <= '0;
            reg_press_c   <= '0;
            reg_valid     <= 1'b0;
            fail_count    <= 0;
            result_count  <= 0;
            pending_count <= 0;
            expected_q.delete();
        end
        else
        begin
            if (done)
            begin
                result_count <= result_count + 1;
                if (expected_q.size() == 0)
                begin
                    $error("result with no item waiting");
                    fail_count <= fail_count + 1;
                end
                else
                begin
                    exp_r = expected_q.pop_front();
                    if (press_q6 !== exp_r.press || temp_q16 !== exp_r.temp
                        || error_code !== exp_r.err)
                    begin
                        fail_count <= fail_count + 1;
                        if (press_q6 !== exp_r.press)
                            $error("press_q6 expected %0d actual %0d", exp_r.press, press_q6);
                        if (temp_q16 !== exp_r.temp)
                            $error("temp_q16 expected %0d actual %0d", exp_r.temp, temp_q16);
                        if (error_code !== exp_r.err)
                            $error("error_code expected %0d actual %0d", exp_r.err,
                                   error_code);
                    end
                end
            end
            // Items taken at this edge see the registers as they were before it.
            if (start && !busy)
                expected_q.push_back(compensate(raw_press, raw_temp));
            pending_count <= expected_q.size();
            if (cfg_we)
            begin
                case (cfg_idx)
                    IDX_TRIM_TEMP:    reg_temp    <= cfg_wdata[39:0];
                    IDX_TRIM_PRESS_A: reg_press_a <= cfg_wdata[47:0];
                    IDX_TRIM_PRESS_B: reg_press_b <= cfg_wdata[47:0];
                    IDX_TRIM_PRESS_C: reg_press_c <= cfg_wdata[31:0];
                    IDX_TRIM_VALID:   reg_valid   <= cfg_wdata[0];
                    default: ;
                endcase
            end
        end
    end
endmodule

/* verif/tb.sv */
// ----------------------------------------------------------------------------
// tb: top-level testbench for barometric trim compensation
// Loads several trim sets, drives directed and random pressure and
// temperature items with random gaps, and reports the checker's verdict.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;
    import btc_pkg::*;

    localparam int LATENCY   = 13;
    localparam int WATCHDOG  = 5000;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic                  busy;
    logic [23:0]           raw_press = '0;
    logic [23:0]           raw_temp = '0;
    logic                  done;
    logic [23:0]           press_q6;
    logic signed [23:0]    temp_q16;
    logic                  error_code;
    logic                  cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]  cfg_idx = '0;
    logic [CFG_DATA_W-1:0] cfg_wdata = '0;
    int                    fail_count;
    int                    pending_count;
    int                    result_count;
    int                    idle_cycles = 0;
    int                    items_sent = 0;

    always #5 clk = ~clk;

    barometric_trim_compensation DUT (.*);

    btc_checker checker_i (.*);

    // The watchdog counts cycles in which neither an item nor a result moves.
    always @(posedge clk)
    begin
        if ((start && !busy) || done || !rst_n)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles > WATCHDOG)
        begin
            $display("tb failed");
            $finish;
        end
    end

    // Writes one trim register; the block must be idle when this is called.
    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [47:0] value);
        cfg_we    <= 1'b1;
        cfg_idx   <= idx;
        cfg_wdata <= value;
        @(negedge clk);
        cfg_we    <= 1'b0;
    endtask

    // Waits until every expected result has come and the pipeline has drained.
    task automatic drain();
        while (pending_count != 0)
            @(negedge clk);
        repeat (LATENCY + 2) @(negedge clk);
    endtask

    task automatic load_trim(input logic [47:0] tt, input logic [47:0] pa,
                             input logic [47:0] pb, input logic [47:0] pc,
                             input logic vld);
        drain();
        write_reg(IDX_TRIM_TEMP, tt);
        write_reg(IDX_TRIM_PRESS_A, pa);
        write_reg(IDX_TRIM_PRESS_B, pb);
        write_reg(IDX_TRIM_PRESS_C, pc);
        write_reg(IDX_TRIM_VALID, {47'd0, vld});
        // An index past the register list must leave everything unchanged.
        write_reg(3'd5 + 3'($urandom_range(0, 2)), 48'({$urandom, $urandom}));
    endtask

    // Sends one item, optionally after a random gap; start stays high for
    // back-to-back items.
    task automatic send_item(input logic [23:0] p, input logic [23:0] t, input bit gaps);
        int gap;
        gap = 0;
        if (gaps)
            gap = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 40)
                : (($urandom_range(0, 2) == 0) ? $urandom_range(1, 3) : 0);
        if (gap != 0)
        begin
            start <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        start     <= 1'b1;
        raw_press <= p;
        raw_temp  <= t;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        @(negedge clk);
        items_sent++;
    endtask

    // Random raw counts: mostly the sensor's normal range, some anywhere,
    // and a few at the ends.
    function automatic logic [23:0] rand_count();
        case ($urandom_range(0, 9))
            0:       return '0;
            1:       return '1;
            2, 3:    return 24'($urandom);
            default: return 24'($urandom_range(24'h400000, 24'hB00000));
        endcase
    endfunction

    task automatic stop_items();
        start <= 1'b0;
        @(negedge clk);
    endtask

    // Plausible trim set near the ones real parts carry, plus random noise.
    task automatic load_random_trim(input bit extreme);
        logic [47:0] tt, pa, pb, pc;
        if (extreme)
        begin
            tt = 48'({$urandom, $urandom});
            pa = 48'({$urandom, $urandom});
            pb = 48'({$urandom, $urandom});
            pc = 48'({$urandom, $urandom});
        end
        else
        begin
            tt = {8'h00, 8'($urandom_range(0, 255)) - 8'd128 + 8'd0,
                  16'($urandom_range(16'h4000, 16'h6000)), 16'($urandom_range(16'h6000, 16'h7000))};
            pa = {8'($urandom_range(0, 15)), 8'($urandom), 16'($urandom_range(0, 16'h1000)),
                  16'($urandom_range(16'h3000, 16'h5000))};
            pb = {8'($urandom), 8'($urandom), 16'($urandom_range(16'h7000, 16'h8000)),
                  16'($urandom_range(16'h5000, 16'h6000))};
            pc = 48'({8'($urandom), 8'($urandom), 16'($urandom)});
        end
        load_trim(tt, pa, pb, pc, 1'b1);
    endtask

    initial
    begin
        repeat (11) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        // Trim not loaded: every item reports the error status with zeros.
        send_item('0, '0, 0);
        send_item('1, '1, 0);
        stop_items();

        // All-ones trim, then all-zeros trim, both marked valid.
        load_trim('1, '1, '1, '1, 1'b1);
        send_item('0, '0, 0);
        send_item('1, '1, 0);
        send_item(24'h800000, 24'h800000, 0);
        stop_items();
        load_trim('0, '0, '0, '0, 1'b1);
        send_item('0, '1, 0);
        send_item('1, '0, 0);
        stop_items();

        // Extreme signed trim values, to push both outputs into saturation.
        load_trim(48'h7F_0000_FFFF, 48'h7F7F_7FFF_7FFF, 48'h7F7F_FFFF_FFFF,
                  48'h7F7F_7FFF, 1'b1);
        send_item('1, '1, 0);
        send_item('0, '0, 0);
        stop_items();
        load_trim(48'h80_FFFF_0000, 48'h8080_8000_8000, 48'h8080_0000_0000,
                  48'h8080_8000, 1'b1);
        send_item('1, '1, 0);
        send_item('0, 24'h123456, 0);
        stop_items();

        // A realistic trim set with a sweep of counts.
        load_trim(48'hF6_4B00_6A00, 48'h0511_0400_4200, 48'h1FE3_7800_5800,
                  48'hF10A_1234, 1'b1);
        for (int i = 0; i < 8; i++)
            send_item(24'(i * 24'h200000), 24'(24'hFFFFFF - i * 24'h200000), 0);
        stop_items();

        // Dropping trim_valid again brings back the error status.
        load_trim(48'hF6_4B00_6A00, 48'h0511_0400_4200, 48'h1FE3_7800_5800,
                  48'hF10A_1234, 1'b0);
        send_item(24'h600000, 24'h700000, 0);
        stop_items();

        // Random phases: each one loads a new trim set and streams items,
        // some back to back and some with gaps.
        for (int ph = 0; ph < 14; ph++)
        begin
            load_random_trim(ph % 4 == 3);
            for (int i = 0; i < 75; i++)
                send_item(rand_count(), rand_count(), ph % 5 != 1);
            stop_items();
        end

        drain();
        $display("Covered %0d items and %0d results over 20 trim settings,", items_sent,
                 result_count);
        $display("including invalid trim, register extremes and saturation.");
        if (fail_count == 0)
            $display("tb passed");
        else
            $display("tb failed");
        $finish;
    end
endmodule

/* filelist.f */
hw/rtl/btc_pkg.sv
hw/rtl/btc_mul.sv
hw/rtl/btc_trim_regs.sv
hw/rtl/barometric_trim_compensation.sv
hw/rtl/btc_checker.sv
verif/btc_checker.sv
verif/tb.sv
